// ===== hdl/dq_pkg.sv =====
// shared codes and widths for the double-ended queue
package dq_pkg;

  // payload widths fixed by the interface
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

// ===== hdl/dq_mem.sv =====
// element store: one write port, one registered read port
module dq_mem #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [IW-1:0]             wr_addr,
  input  logic [dq_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [IW-1:0]             rd_addr,
  output logic [dq_pkg::DATA_W-1:0] rd_data
);

  logic [dq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [dq_pkg::DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/double_ended_queue.sv =====
// double-ended queue top level: control, index arithmetic and result register
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | start / busy       | in_func, in_push_value
//  result   | out_valid (strobe) | out_popped_value, out_status,
//           |                    | out_entry_count, out_is_empty,
//           |                    | out_front_value, out_back_value
//
// for pushes, no-change codes and failed pops the result shows the cycle after
// the accepting edge and the next beat may be accepted meanwhile.
// a successful pop passes through the read state: the store is read for the new
// front or back entry (registered read), with busy high during the read state.
// front and back values are cached in registers, so pushes never read the store.
// rst_n synchronously clears head, count and control; store contents are kept.
// results cannot be stalled: each is shown for exactly one cycle.
module double_ended_queue #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [dq_pkg::FUNC_W-1:0]   in_func,
  input  logic signed [dq_pkg::DATA_W-1:0] in_push_value,
  output logic                        out_valid,
  output logic signed [dq_pkg::DATA_W-1:0] out_popped_value,
  output logic [dq_pkg::STATUS_W-1:0] out_status,
  output logic [dq_pkg::COUNT_W-1:0]  out_entry_count,
  output logic                        out_is_empty,
  output logic signed [dq_pkg::DATA_W-1:0] out_front_value,
  output logic signed [dq_pkg::DATA_W-1:0] out_back_value
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  localparam logic SIDE_FRONT = 1'b0;
  localparam logic SIDE_BACK  = 1'b1;

  // control registers
  logic          state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          side_r, side_nxt;
  logic          out_valid_r, out_valid_nxt;

  // cached end values
  logic [dq_pkg::DATA_W-1:0] front_r, front_nxt;
  logic [dq_pkg::DATA_W-1:0] back_r, back_nxt;

  // result registers
  logic [dq_pkg::DATA_W-1:0]   out_popped_r, out_popped_nxt;
  logic [dq_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [dq_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                        out_empty_r, out_empty_nxt;
  logic [dq_pkg::DATA_W-1:0]   out_front_r, out_front_nxt;
  logic [dq_pkg::DATA_W-1:0]   out_back_r, out_back_nxt;

  // store ports
  logic                      wr_en;
  logic [IW-1:0]             wr_addr;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic [dq_pkg::DATA_W-1:0] rd_data;

  // index arithmetic
  logic [IW-1:0]          head_dec;
  logic [IW-1:0]          head_inc;
  logic [SW-1:0]          tail_sum;
  logic [IW-1:0]          tail_idx;
  logic [CW-1:0]          count_m2;
  logic [SW-1:0]          back2_sum;
  logic [IW-1:0]          back2_idx;
  logic [CW+dq_pkg::COUNT_W-1:0] count_ext;
  logic                   is_full;
  logic                   is_none;

  assign head_dec  = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign head_inc  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;

  // slot after the back: (head + count) mod depth
  assign tail_sum = SW'(head_r) + SW'(count_r);
  always_comb begin
    if (tail_sum >= DEPTH_S) begin
      tail_idx = IW'(tail_sum - DEPTH_S);
    end else begin
      tail_idx = IW'(tail_sum);
    end
  end

  // new back after a back pop: (head + count - 2) mod depth
  assign count_m2  = count_r - CW'(2);
  assign back2_sum = SW'(head_r) + SW'(count_m2);
  always_comb begin
    if (back2_sum >= DEPTH_S) begin
      back2_idx = IW'(back2_sum - DEPTH_S);
    end else begin
      back2_idx = IW'(back2_sum);
    end
  end

  assign is_full = (count_r >= DEPTH_C);
  assign is_none = (count_r == '0);

  // operation sequencing
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    side_nxt       = side_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    out_valid_nxt  = 1'b0;
    out_popped_nxt = out_popped_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    wr_addr        = head_dec;
    rd_en          = 1'b0;
    rd_addr        = head_inc;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt  = 1'b1;
          out_popped_nxt = '0;
          out_status_nxt = dq_pkg::STATUS_OK;
          case (in_func)
            dq_pkg::FUNC_PUSH_FRONT: begin
              if (is_full) begin
                out_status_nxt = dq_pkg::STATUS_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = head_dec;
                head_nxt  = head_dec;
                count_nxt = count_r + 1'b1;
                front_nxt = in_push_value;
                if (is_none) begin
                  back_nxt = in_push_value;
                end
              end
            end
            dq_pkg::FUNC_PUSH_BACK: begin
              if (is_full) begin
                out_status_nxt = dq_pkg::STATUS_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = tail_idx;
                count_nxt = count_r + 1'b1;
                back_nxt  = in_push_value;
                if (is_none) begin
                  front_nxt = in_push_value;
                end
              end
            end
            dq_pkg::FUNC_POP_FRONT: begin
              if (is_none) begin
                out_status_nxt = dq_pkg::STATUS_EMPTY;
              end else begin
                out_popped_nxt = front_r;
                head_nxt       = head_inc;
                count_nxt      = count_r - 1'b1;
                rd_en          = 1'b1;
                rd_addr        = head_inc;
                side_nxt       = SIDE_FRONT;
                state_nxt      = ST_READ;
                out_valid_nxt  = 1'b0;
              end
            end
            dq_pkg::FUNC_POP_BACK: begin
              if (is_none) begin
                out_status_nxt = dq_pkg::STATUS_EMPTY;
              end else begin
                out_popped_nxt = back_r;
                count_nxt      = count_r - 1'b1;
                rd_en          = 1'b1;
                rd_addr        = back2_idx;
                side_nxt       = SIDE_BACK;
                state_nxt      = ST_READ;
                out_valid_nxt  = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // refill the cached end from the store
        if (side_r == SIDE_BACK) begin
          back_nxt = rd_data;
        end else begin
          front_nxt = rd_data;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result fields from the state after the operation
  assign count_ext = {{dq_pkg::COUNT_W{1'b0}}, count_nxt};
  always_comb begin
    out_count_nxt = count_ext[dq_pkg::COUNT_W-1:0];
    out_empty_nxt = (count_nxt == '0);
    out_front_nxt = out_empty_nxt ? '0 : front_nxt;
    out_back_nxt  = out_empty_nxt ? '0 : back_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      side_r      <= SIDE_FRONT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // cached ends and result payload
  always_ff @(posedge clk) begin
    front_r      <= front_nxt;
    back_r       <= back_nxt;
    out_popped_r <= out_popped_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_front_r  <= out_front_nxt;
    out_back_r   <= out_back_nxt;
  end

  dq_mem #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy             = (state_r == ST_READ);
  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = out_count_r;
  assign out_is_empty     = out_empty_r;
  assign out_front_value  = out_front_r;
  assign out_back_value   = out_back_r;

endmodule

// ===== dv/double_ended_queue_test.sv =====
// testbench for the double-ended queue: directed corners, fill and drain, random mixes
`timescale 1ns / 100ps

module double_ended_queue_test;

  localparam int QDEPTH = 64;
  localparam int IDX_W = $clog2(QDEPTH);
  localparam int CYCLE_LIMIT = 100000;

  // codes the package leaves unnamed
  localparam logic [dq_pkg::FUNC_W-1:0] FUNC_NO_CHANGE = 3'd4;
  localparam logic [dq_pkg::FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [dq_pkg::FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  // operation mix of one random stretch
  typedef enum int {MIX_PUSH_HEAVY, MIX_POP_HEAVY, MIX_BALANCED} op_mix_t;

  typedef struct {
    logic signed [dq_pkg::DATA_W-1:0] popped;
    logic [dq_pkg::STATUS_W-1:0]      status;
    logic [dq_pkg::COUNT_W-1:0]       count;
    logic                             empty;
    logic signed [dq_pkg::DATA_W-1:0] front;
    logic signed [dq_pkg::DATA_W-1:0] back;
  } deque_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [dq_pkg::FUNC_W-1:0] in_func = '0;
  logic signed [dq_pkg::DATA_W-1:0] in_push_value = '0;
  logic busy;
  logic out_valid;
  logic signed [dq_pkg::DATA_W-1:0] out_popped_value;
  logic [dq_pkg::STATUS_W-1:0] out_status;
  logic [dq_pkg::COUNT_W-1:0] out_entry_count;
  logic out_is_empty;
  logic signed [dq_pkg::DATA_W-1:0] out_front_value;
  logic signed [dq_pkg::DATA_W-1:0] out_back_value;

  // mirror of the queue contents
  logic signed [dq_pkg::DATA_W-1:0] mirror_store [QDEPTH];
  logic [IDX_W-1:0] mirror_head = '0;
  logic [dq_pkg::COUNT_W-1:0] mirror_count = '0;

  deque_view_t awaited_views [$];
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit gapless = 1'b0;

  double_ended_queue #(.DEPTH(QDEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_push_value(in_push_value),
    .out_valid(out_valid),
    .out_popped_value(out_popped_value),
    .out_status(out_status),
    .out_entry_count(out_entry_count),
    .out_is_empty(out_is_empty),
    .out_front_value(out_front_value),
    .out_back_value(out_back_value)
  );

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // apply one operation to the mirror and return the view it leaves behind
  function automatic deque_view_t deque_apply(input logic [dq_pkg::FUNC_W-1:0] func,
                                              input logic signed [dq_pkg::DATA_W-1:0] value);
    deque_view_t view;
    logic [IDX_W-1:0] slot;
    view.popped = '0;
    view.status = dq_pkg::STATUS_OK;
    view.front = '0;
    view.back = '0;
    case (func)
      dq_pkg::FUNC_PUSH_FRONT, dq_pkg::FUNC_PUSH_BACK: begin
        if (mirror_count >= QDEPTH) begin
          view.status = dq_pkg::STATUS_FULL;
        end else if (func == dq_pkg::FUNC_PUSH_FRONT) begin
          mirror_head = mirror_head - 1'b1;
          mirror_store[mirror_head] = value;
          mirror_count = mirror_count + 1'b1;
        end else begin
          slot = mirror_head + mirror_count[IDX_W-1:0];
          mirror_store[slot] = value;
          mirror_count = mirror_count + 1'b1;
        end
      end
      dq_pkg::FUNC_POP_FRONT, dq_pkg::FUNC_POP_BACK: begin
        if (mirror_count == 0) begin
          view.status = dq_pkg::STATUS_EMPTY;
        end else if (func == dq_pkg::FUNC_POP_FRONT) begin
          view.popped = mirror_store[mirror_head];
          mirror_head = mirror_head + 1'b1;
          mirror_count = mirror_count - 1'b1;
        end else begin
          slot = mirror_head + mirror_count[IDX_W-1:0] - 1'b1;
          view.popped = mirror_store[slot];
          mirror_count = mirror_count - 1'b1;
        end
      end
      default: ;
    endcase
    if (mirror_count != 0) begin
      slot = mirror_head + mirror_count[IDX_W-1:0] - 1'b1;
      view.front = mirror_store[mirror_head];
      view.back = mirror_store[slot];
    end
    view.count = mirror_count;
    view.empty = (mirror_count == 0);
    return view;
  endfunction

  // values weighted towards the sign and range corners
  function automatic logic signed [dq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [dq_pkg::FUNC_W-1:0] pick_func(input op_mix_t mix);
    int roll;
    int push_pct;
    roll = $urandom_range(0, 99);
    push_pct = (mix == MIX_PUSH_HEAVY) ? 72 : (mix == MIX_POP_HEAVY) ? 23 : 47;
    if (roll < push_pct)
      return $urandom_range(0, 1) ? dq_pkg::FUNC_PUSH_FRONT : dq_pkg::FUNC_PUSH_BACK;
    else if (roll < 95)
      return $urandom_range(0, 1) ? dq_pkg::FUNC_POP_FRONT : dq_pkg::FUNC_POP_BACK;
    else
      return dq_pkg::FUNC_W'($urandom_range(FUNC_NO_CHANGE, FUNC_UNUSED_HI));
  endfunction

  // sender pacing: bursts of beats with idle gaps between them
  task automatic pace();
    if (!gapless && burst_left == 0) begin
      start <= 1'b0;
      in_func <= dq_pkg::FUNC_W'($urandom);
      in_push_value <= $urandom;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // send one beat; entered and left at a falling edge with start still high
  task automatic send_op(input logic [dq_pkg::FUNC_W-1:0] func,
                         input logic signed [dq_pkg::DATA_W-1:0] value);
    pace();
    start <= 1'b1;
    in_func <= func;
    in_push_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_views.insert(awaited_views.size(), deque_apply(func, value));
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  // result check against the oldest prediction
  always @(posedge clk) begin
    deque_view_t want;
    if (rst_n && out_valid) begin
      if (awaited_views.size() == 0) begin
        $error("result beat with no operation outstanding");
        error_count++;
      end else begin
        want = awaited_views[0];
        awaited_views.delete(0);
        if (out_popped_value !== want.popped) begin
          $error("out_popped_value: expected %0d, got %0d", want.popped, out_popped_value);
          error_count++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_entry_count !== want.count) begin
          $error("out_entry_count: expected %0d, got %0d", want.count, out_entry_count);
          error_count++;
        end
        if (out_is_empty !== want.empty) begin
          $error("out_is_empty: expected %0d, got %0d", want.empty, out_is_empty);
          error_count++;
        end
        if (out_front_value !== want.front) begin
          $error("out_front_value: expected %0d, got %0d", want.front, out_front_value);
          error_count++;
        end
        if (out_back_value !== want.back) begin
          $error("out_back_value: expected %0d, got %0d", want.back, out_back_value);
          error_count++;
        end
      end
    end
  end

  // empty pops, no-change and unused codes, corner values, head wrap below zero
  task automatic test_directed_corners();
    send_op(dq_pkg::FUNC_POP_FRONT, 32'sh7fff_ffff);
    send_op(dq_pkg::FUNC_POP_BACK, -32'sd1);
    send_op(FUNC_NO_CHANGE, 32'sh1234_5678);
    for (int f = FUNC_UNUSED_LO; f <= FUNC_UNUSED_HI; f++)
      send_op(f[dq_pkg::FUNC_W-1:0], $urandom);
    send_op(dq_pkg::FUNC_PUSH_FRONT, 32'sh8000_0000);
    send_op(dq_pkg::FUNC_PUSH_BACK, 32'sh7fff_ffff);
    send_op(dq_pkg::FUNC_PUSH_FRONT, -32'sd1);
    send_op(dq_pkg::FUNC_PUSH_BACK, '0);
    send_op(FUNC_NO_CHANGE, -32'sd1);
    send_op(FUNC_UNUSED_HI, 32'sh8000_0000);
    send_op(dq_pkg::FUNC_POP_BACK, '0);
    send_op(dq_pkg::FUNC_POP_FRONT, '0);
    send_op(dq_pkg::FUNC_POP_BACK, '0);
    send_op(dq_pkg::FUNC_POP_FRONT, '0);
    send_op(dq_pkg::FUNC_POP_BACK, 32'sh5555_5555);
  endtask

  // fill past capacity so pushes are dropped, then drain past empty
  task automatic test_fill_and_drain();
    repeat (QDEPTH + 3)
      send_op($urandom_range(0, 1) ? dq_pkg::FUNC_PUSH_FRONT : dq_pkg::FUNC_PUSH_BACK,
              pick_value());
    send_op(FUNC_NO_CHANGE, pick_value());
    repeat (QDEPTH + 2)
      send_op($urandom_range(0, 1) ? dq_pkg::FUNC_POP_FRONT : dq_pkg::FUNC_POP_BACK,
              pick_value());
  endtask

  // random stretches with shifting operation mix and pacing
  task automatic test_random_mix(input int beats);
    int sent;
    int stretch;
    op_mix_t mix;
    sent = 0;
    while (sent < beats) begin
      mix = op_mix_t'($urandom_range(0, 2));
      gapless = ($urandom_range(0, 3) == 0);
      stretch = $urandom_range(20, 120);
      for (int i = 0; i < stretch && sent < beats; i++) begin
        send_op(pick_func(mix), pick_value());
        sent++;
      end
    end
    gapless = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_corners();
    test_fill_and_drain();
    test_random_mix(300);
    test_fill_and_drain();
    test_random_mix(270);
    start <= 1'b0;

    while (awaited_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0 && awaited_views.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dq_pkg.sv
hdl/dq_mem.sv
hdl/double_ended_queue.sv
dv/double_ended_queue_test.sv
